>>> design/ttbd_pkg.sv
package ttbd_pkg;

   localparam int unsigned STAMP_W     = 32;
   localparam int unsigned SUM_W       = STAMP_W + 2;
   localparam int unsigned CMP_W       = STAMP_W + 3;
   localparam int unsigned HIST_DEPTH  = 3;
   localparam int unsigned CNT_W       = 6;
   localparam int unsigned RECIP_W     = 17;
   localparam int unsigned PROD_W      = SUM_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 35;

   localparam logic [CNT_W-1:0]   DIV_STEPS          = CNT_W'(SUM_W);
   localparam logic [STAMP_W-1:0] RESET_MINUTE_TICKS = 32'd60000000;
   // (2^35 + 1) / 3 split into two 17-bit halves
   localparam logic [RECIP_W-1:0] RECIP_LO           = 17'h0AAAB;
   localparam logic [RECIP_W-1:0] RECIP_HI           = 17'h15555;

   typedef struct packed {
      logic [STAMP_W-1:0] time_a;
      logic [STAMP_W-1:0] time_b;
      logic [STAMP_W-1:0] now_ticks;
   } req_payload_type;

   typedef struct packed {
      logic [STAMP_W-1:0] bpm_a;
      logic [STAMP_W-1:0] bpm_b;
      logic [STAMP_W-1:0] period_a;
      logic [STAMP_W-1:0] period_b;
      logic               active_channel;
      logic               updated_a;
      logic               updated_b;
   } rsp_payload_type;

   typedef struct packed {
      logic latch_in;
      logic chan;
      logic capture;
      logic test;
      logic start_div3;
      logic take_avg;
      logic start_bpm;
      logic commit;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic changed;
      logic pass;
      logic avg_zero;
      logic div_busy;
      logic out_full;
   } dp_status_type;

endpackage

>>> design/ttbd_req_if.sv
interface ttbd_req_if;
   import ttbd_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/ttbd_rsp_if.sv
interface ttbd_rsp_if;
   import ttbd_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> design/ttbd_datapath.sv
module ttbd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [31:0]              csr_write_data,
   input  ttbd_pkg::req_payload_type req_payload,
   input  ttbd_pkg::ctrl_cmd_type   cmd,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   output ttbd_pkg::rsp_payload_type rsp_payload,
   output ttbd_pkg::dp_status_type  status
);
   import ttbd_pkg::*;

   logic [STAMP_W-1:0] minute_ticks_ff;
   logic [STAMP_W-1:0] stamp_ff [2];
   logic [STAMP_W-1:0] now_ff;
   logic [STAMP_W-1:0] hist_ff [2][HIST_DEPTH];
   logic [STAMP_W-1:0] iv0_ff;
   logic [STAMP_W-1:0] iv1_ff;
   logic [STAMP_W-1:0] iv2_ff;
   logic               pass_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [PROD_W-1:0]  prod_lo_ff;
   logic [PROD_W-1:0]  prod_hi_ff;
   logic [STAMP_W-1:0] avg_ff;
   logic [STAMP_W-1:0] tempo_ff [2];
   logic [STAMP_W-1:0] period_ff [2];
   logic [STAMP_W-1:0] utime_ff [2];
   logic [1:0]         upd_ff;

   logic               div_busy_ff;
   logic [CNT_W-1:0]   div_cnt_ff;
   logic [STAMP_W-1:0] div_rem_ff;
   logic [SUM_W-1:0]   div_quo_ff;
   logic [STAMP_W-1:0] div_dvs_ff;

   logic               rsp_valid_ff;
   rsp_payload_type    rsp_payload_ff;
   rsp_payload_type    rsp_payload_in;

   logic [STAMP_W-1:0] cur_stamp;
   logic [STAMP_W-1:0] h0;
   logic [STAMP_W-1:0] h1;
   logic [STAMP_W-1:0] h2;
   logic               changed;
   logic [CMP_W-1:0]   four_iv0;
   logic [CMP_W-1:0]   four_iv1;
   logic [CMP_W-1:0]   four_iv2;
   logic [CMP_W-1:0]   five_iv0;
   logic [CMP_W-1:0]   five_iv2;
   logic               pass_c;
   logic [SUM_W-1:0]   sum_c;
   logic [2*SUM_W-1:0] prod_c;
   logic [STAMP_W:0]   div_shift;
   logic [STAMP_W+1:0] div_diff;
   logic               div_borrow;

   assign cur_stamp = stamp_ff[cmd.chan];
   assign h0        = hist_ff[cmd.chan][0];
   assign h1        = hist_ff[cmd.chan][1];
   assign h2        = hist_ff[cmd.chan][2];
   assign changed   = (cur_stamp != h2);

   assign four_iv0 = {1'b0, iv0_ff, 2'b00};
   assign four_iv1 = {1'b0, iv1_ff, 2'b00};
   assign four_iv2 = {1'b0, iv2_ff, 2'b00};
   assign five_iv0 = four_iv0 + {3'b000, iv0_ff};
   assign five_iv2 = four_iv2 + {3'b000, iv2_ff};
   assign pass_c   = (four_iv1 < five_iv0) && (four_iv2 < five_iv0) && (four_iv0 < five_iv2);
   assign sum_c    = {2'b00, iv0_ff} + {2'b00, iv1_ff} + {2'b00, iv2_ff};

   // sum times the reciprocal of three, scaled by 2^35
   assign prod_c = {prod_hi_ff, {RECIP_W{1'b0}}} + {{RECIP_W{1'b0}}, prod_lo_ff};

   assign div_shift  = {div_rem_ff, div_quo_ff[SUM_W-1]};
   assign div_diff   = {1'b0, div_shift} - {2'b00, div_dvs_ff};
   assign div_borrow = div_diff[STAMP_W+1];

   always_comb begin
      rsp_payload_in.bpm_a          = tempo_ff[0];
      rsp_payload_in.bpm_b          = tempo_ff[1];
      rsp_payload_in.period_a       = period_ff[0];
      rsp_payload_in.period_b       = period_ff[1];
      rsp_payload_in.active_channel = (utime_ff[0] > utime_ff[1]) ? 1'b0 : 1'b1;
      rsp_payload_in.updated_a      = upd_ff[0];
      rsp_payload_in.updated_b      = upd_ff[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         minute_ticks_ff <= RESET_MINUTE_TICKS;
         for (int c = 0; c < 2; c++) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
               hist_ff[c][k] <= '0;
            end
            tempo_ff[c]  <= '0;
            period_ff[c] <= '0;
            utime_ff[c]  <= '0;
         end
         upd_ff       <= '0;
         div_busy_ff  <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            minute_ticks_ff <= csr_write_data;
         end
         if (cmd.latch_in) begin
            upd_ff <= '0;
         end
         // shift the stamp history, oldest first
         if (cmd.capture && changed) begin
            hist_ff[cmd.chan][0] <= h1;
            hist_ff[cmd.chan][1] <= h2;
            hist_ff[cmd.chan][2] <= cur_stamp;
         end
         if (cmd.start_bpm) begin
            div_busy_ff <= 1'b1;
            div_cnt_ff  <= DIV_STEPS;
         end else if (div_busy_ff) begin
            div_cnt_ff <= div_cnt_ff - CNT_W'(1);
            if (div_cnt_ff == CNT_W'(1)) begin
               div_busy_ff <= 1'b0;
            end
         end
         if (cmd.commit) begin
            tempo_ff[cmd.chan]  <= div_quo_ff[STAMP_W-1:0];
            period_ff[cmd.chan] <= avg_ff;
            utime_ff[cmd.chan]  <= now_ff;
            upd_ff[cmd.chan]    <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         stamp_ff[0] <= req_payload.time_a;
         stamp_ff[1] <= req_payload.time_b;
         now_ff      <= req_payload.now_ticks;
      end
      if (cmd.capture && changed) begin
         iv0_ff <= h1 - h0;
         iv1_ff <= h2 - h1;
         iv2_ff <= cur_stamp - h2;
      end
      if (cmd.test) begin
         pass_ff <= pass_c;
         sum_ff  <= sum_c;
      end
      if (cmd.start_div3) begin
         prod_lo_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP_LO);
         prod_hi_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP_HI);
      end
      if (cmd.start_bpm) begin
         div_rem_ff <= '0;
         div_quo_ff <= {2'b00, minute_ticks_ff};
         div_dvs_ff <= avg_ff;
      end else if (div_busy_ff) begin
         div_rem_ff <= div_borrow ? div_shift[STAMP_W-1:0] : div_diff[STAMP_W-1:0];
         div_quo_ff <= {div_quo_ff[SUM_W-2:0], ~div_borrow};
      end
      if (cmd.take_avg) begin
         avg_ff <= prod_c[RECIP_SHIFT+STAMP_W-1:RECIP_SHIFT];
      end
      if (cmd.load_rsp) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_comb begin
      status.changed  = changed;
      status.pass     = pass_ff;
      status.avg_zero = (avg_ff == '0);
      status.div_busy = div_busy_ff;
      status.out_full = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> design/ttbd_ctrl.sv
module ttbd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  ttbd_pkg::dp_status_type status,
   output ttbd_pkg::ctrl_cmd_type  cmd
);
   import ttbd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHAN   = 3'd1;
   localparam logic [2:0] S_TEST   = 3'd2;
   localparam logic [2:0] S_DECIDE = 3'd3;
   localparam logic [2:0] S_DIV3   = 3'd4;
   localparam logic [2:0] S_AVG    = 3'd5;
   localparam logic [2:0] S_BPM    = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       chan_ff;
   logic       chan_in;
   logic       next_chan;

   always_comb begin
      cmd       = '0;
      cmd.chan  = chan_ff;
      in_ready  = 1'b0;
      state_in  = state_ff;
      chan_in   = chan_ff;
      next_chan = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.latch_in = 1'b1;
               chan_in      = 1'b0;
               state_in     = S_CHAN;
            end
         end
         S_CHAN: begin
            cmd.capture = 1'b1;
            if (status.changed) begin
               state_in = S_TEST;
            end else begin
               next_chan = 1'b1;
            end
         end
         S_TEST: begin
            cmd.test = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.pass) begin
               cmd.start_div3 = 1'b1;
               state_in       = S_DIV3;
            end else begin
               next_chan = 1'b1;
            end
         end
         S_DIV3: begin
            if (!status.div_busy) begin
               cmd.take_avg = 1'b1;
               state_in     = S_AVG;
            end
         end
         S_AVG: begin
            if (status.avg_zero) begin
               next_chan = 1'b1;
            end else begin
               cmd.start_bpm = 1'b1;
               state_in      = S_BPM;
            end
         end
         S_BPM: begin
            if (!status.div_busy) begin
               cmd.commit = 1'b1;
               next_chan  = 1'b1;
            end
         end
         S_OUT: begin
            if (!status.out_full) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // advance to channel b, then to the output
      if (next_chan) begin
         if (!chan_ff) begin
            chan_in  = 1'b1;
            state_in = S_CHAN;
         end else begin
            state_in = S_OUT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         chan_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

>>> design/tap_tempo_bpm_detector.sv
// Two-channel tap-tempo detector. Each request transaction carries the latest trigger stamp of
// channels a and b and the current tick; each yields exactly one response transaction with the
// tempo, average period and update flag of both channels and the most recently updated channel.
// A channel whose stamp changed shifts it into a three-deep history and accepts a new tempo when
// its second and third intervals are each under 1.25 times its first, the first is under 1.25
// times the third and their average is nonzero; bpm is csr_write_data (ticks per minute, reset
// 60000000) divided by that average. Both channels are handled in turn by one controller and one
// datapath: the average comes from a multiplication by the reciprocal of three, the tempo from a
// shared 34-step restoring divider. A finished response waits in an output register while the
// next request is taken. Write the register only while the block is idle.
module tap_tempo_bpm_detector (
   input  logic        clock,
   input  logic        reset,
   ttbd_req_if.sink    req_chan,
   ttbd_rsp_if.source  rsp_chan,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import ttbd_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ttbd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   ttbd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_chan.payload),
      .cmd              (cmd),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_payload      (rsp_chan.payload),
      .status           (status)
   );

endmodule
